// File: hw/rtl/rgsc_pkg.sv
// shared types, constants and helpers of the rooted graph shell compare block
package rgsc_pkg;

   localparam int MAX_ATOMS    = 64;
   localparam int ELEMENT_BITS = 7;
   localparam int IDX_BITS     = $clog2(MAX_ATOMS);
   localparam int CNT_BITS     = $clog2(MAX_ATOMS + 1);
   localparam int LEVEL_BITS   = IDX_BITS;
   localparam int QE_BITS      = IDX_BITS + LEVEL_BITS;
   localparam int ELEM_VALUES  = 1 << ELEMENT_BITS;
   localparam int DIFF_BITS    = CNT_BITS + 1;
   localparam int NZ_BITS      = ELEMENT_BITS + 1;

   typedef enum logic [1:0] {
      ACT_LOAD_FIRST  = 2'd0,
      ACT_LOAD_SECOND = 2'd1,
      ACT_COMPARE     = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      FAIL_NONE     = 3'd0,
      FAIL_DEGREE   = 3'd1,
      FAIL_NEIGHBOR = 3'd2,
      FAIL_WALK     = 3'd3,
      FAIL_SHELL    = 3'd4
   } fail_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT_RD,
      ST_NB_INIT,
      ST_NB_PICK,
      ST_UPD_RD_A,
      ST_UPD_WR_A,
      ST_UPD_RD_B,
      ST_UPD_WR_B,
      ST_NB_DONE,
      ST_WALK_INIT,
      ST_DEQ,
      ST_NODE_RD,
      ST_NODE_LOAD,
      ST_ENQ,
      ST_WALK_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     take;
      logic     root_rd;
      logic     nb_init;
      logic     nb_pick;
      logic     upd_rd_a;
      logic     upd_wr_a;
      logic     upd_rd_b;
      logic     upd_wr_b;
      logic     walk_init;
      logic     deq;
      logic     node_rd;
      logic     node_load;
      logic     enq;
      logic     emit;
      logic     clear;
      fail_type reason;
   } cmd_type;

   typedef struct packed {
      logic req_is_cmp;
      logic root_bad;
      logic nb_empty;
      logic cnt_eq;
      logic nz_zero;
      logic q_a_empty;
      logic q_b_empty;
      logic lv_eq;
      logic lv_changed;
      logic inc_en;
      logic dec_en;
      logic enq_empty;
      logic rsp_free;
      logic clear_done;
   } sts_type;

   function automatic logic [IDX_BITS-1:0] lowest_bit(input logic [MAX_ATOMS-1:0] v);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int k = MAX_ATOMS - 1; k >= 0; k--) begin
         if (v[k]) idx = IDX_BITS'(k);
      end
      return idx;
   endfunction

endpackage

// File: hw/rtl/rooted_graph_shell_compare.sv
// top level of the rooted graph shell compare block
//
// request words carry an action: load an atom of the first or second
// molecule (atomic number plus neighbor row), or compare two root atoms.
// a load gives no response word.
// a compare gives one response word: equivalent and a fail reason.
// a compare first checks the neighbors of the two roots, then walks atom pairs
// outward from the roots, running a dequeue/update/enqueue sequence per dequeued
// atom pair against the element count memory.
// one compare is worked at a time; loads are taken while a response waits.
// reset: atom count returns to 64 and a pass over all 128 entries clears the
// element count memory, with req_stall high throughout. a compare that fails
// with unbalanced counts runs the same pass after its response is registered.
// atom stores hold garbage until loaded.
// a stalled response holds in the output register; a compare that finishes
// meanwhile waits for it to drain before posting its own word.
module rooted_graph_shell_compare (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [rgsc_pkg::IDX_BITS-1:0]     req_atom_index,
   input  logic [rgsc_pkg::ELEMENT_BITS-1:0] req_atomic_number,
   input  logic [rgsc_pkg::MAX_ATOMS-1:0]    req_neighbor_row,
   input  logic [rgsc_pkg::IDX_BITS-1:0]     req_first_atom,
   input  logic [rgsc_pkg::IDX_BITS-1:0]     req_second_atom,
   input  logic                              req_across_molecules,
   input  logic                              csr_wr_en,
   input  logic [rgsc_pkg::CNT_BITS-1:0]     csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_equivalent,
   output logic [2:0]                        rsp_fail_reason
);

   rgsc_pkg::cmd_type cmd;
   rgsc_pkg::sts_type sts;

   rgsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   rgsc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_valid            (req_valid),
      .req_action           (req_action),
      .req_atom_index       (req_atom_index),
      .req_atomic_number    (req_atomic_number),
      .req_neighbor_row     (req_neighbor_row),
      .req_first_atom       (req_first_atom),
      .req_second_atom      (req_second_atom),
      .req_across_molecules (req_across_molecules),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_equivalent       (rsp_equivalent),
      .rsp_fail_reason      (rsp_fail_reason)
   );

   assign req_stall = !cmd.take;

`ifndef ASSERT_OFF
   a_clean_counts_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> sts.nz_zero)
      else $error("element counts not balanced while taking requests");

   a_single_count_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.upd_wr_a, cmd.upd_wr_b, cmd.clear}))
      else $error("two writes to the element count memory in one cycle");

   a_result_consistent: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid && (rsp_equivalent == (rsp_fail_reason == rgsc_pkg::FAIL_NONE)))
      else $error("posted response word inconsistent");
`endif

endmodule

// File: hw/rtl/rgsc_ctrl.sv
// controller state machine sequencing loads, neighbor check, walk and result
module rgsc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  rgsc_pkg::sts_type sts,
   output rgsc_pkg::cmd_type cmd
);

   rgsc_pkg::state_type state_ff, state_in;
   rgsc_pkg::fail_type  reason_ff, reason_in;
   logic                walk_phase_ff, walk_phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rgsc_pkg::ST_CLEAR;
         reason_ff     <= rgsc_pkg::FAIL_NONE;
         walk_phase_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         reason_ff     <= reason_in;
         walk_phase_ff <= walk_phase_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      reason_in     = reason_ff;
      walk_phase_in = walk_phase_ff;
      unique case (state_ff)
         rgsc_pkg::ST_CLEAR: begin
            if (sts.clear_done) state_in = rgsc_pkg::ST_IDLE;
         end
         rgsc_pkg::ST_IDLE: begin
            if (req_valid && sts.req_is_cmp) begin
               if (sts.root_bad) begin
                  reason_in = rgsc_pkg::FAIL_WALK;
                  state_in  = rgsc_pkg::ST_EMIT;
               end else begin
                  state_in = rgsc_pkg::ST_ROOT_RD;
               end
            end
         end
         rgsc_pkg::ST_ROOT_RD: state_in = rgsc_pkg::ST_NB_INIT;
         rgsc_pkg::ST_NB_INIT: state_in = rgsc_pkg::ST_NB_PICK;
         rgsc_pkg::ST_NB_PICK: begin
            walk_phase_in = 1'b0;
            state_in = sts.nb_empty ? rgsc_pkg::ST_NB_DONE : rgsc_pkg::ST_UPD_RD_A;
         end
         rgsc_pkg::ST_UPD_RD_A: begin
            state_in = sts.inc_en ? rgsc_pkg::ST_UPD_WR_A : rgsc_pkg::ST_UPD_RD_B;
         end
         rgsc_pkg::ST_UPD_WR_A: state_in = rgsc_pkg::ST_UPD_RD_B;
         rgsc_pkg::ST_UPD_RD_B: begin
            if (sts.dec_en) state_in = rgsc_pkg::ST_UPD_WR_B;
            else state_in = walk_phase_ff ? rgsc_pkg::ST_ENQ : rgsc_pkg::ST_NB_PICK;
         end
         rgsc_pkg::ST_UPD_WR_B: begin
            state_in = walk_phase_ff ? rgsc_pkg::ST_ENQ : rgsc_pkg::ST_NB_PICK;
         end
         rgsc_pkg::ST_NB_DONE: begin
            if (!sts.cnt_eq) begin
               reason_in = rgsc_pkg::FAIL_DEGREE;
               state_in  = rgsc_pkg::ST_EMIT;
            end else if (!sts.nz_zero) begin
               reason_in = rgsc_pkg::FAIL_NEIGHBOR;
               state_in  = rgsc_pkg::ST_EMIT;
            end else begin
               state_in = rgsc_pkg::ST_WALK_INIT;
            end
         end
         rgsc_pkg::ST_WALK_INIT: state_in = rgsc_pkg::ST_DEQ;
         rgsc_pkg::ST_DEQ: begin
            if (sts.q_a_empty && sts.q_b_empty) begin
               state_in = rgsc_pkg::ST_WALK_END;
            end else if (sts.q_a_empty || sts.q_b_empty) begin
               reason_in = rgsc_pkg::FAIL_WALK;
               state_in  = rgsc_pkg::ST_EMIT;
            end else begin
               state_in = rgsc_pkg::ST_NODE_RD;
            end
         end
         rgsc_pkg::ST_NODE_RD: begin
            if (!sts.lv_eq) begin
               reason_in = rgsc_pkg::FAIL_WALK;
               state_in  = rgsc_pkg::ST_EMIT;
            end else if (sts.lv_changed && !sts.nz_zero) begin
               reason_in = rgsc_pkg::FAIL_SHELL;
               state_in  = rgsc_pkg::ST_EMIT;
            end else begin
               state_in = rgsc_pkg::ST_NODE_LOAD;
            end
         end
         rgsc_pkg::ST_NODE_LOAD: begin
            walk_phase_in = 1'b1;
            state_in      = rgsc_pkg::ST_UPD_RD_A;
         end
         rgsc_pkg::ST_ENQ: begin
            if (sts.enq_empty) state_in = rgsc_pkg::ST_DEQ;
         end
         rgsc_pkg::ST_WALK_END: begin
            reason_in = sts.nz_zero ? rgsc_pkg::FAIL_NONE : rgsc_pkg::FAIL_SHELL;
            state_in  = rgsc_pkg::ST_EMIT;
         end
         rgsc_pkg::ST_EMIT: begin
            if (sts.rsp_free) state_in = sts.nz_zero ? rgsc_pkg::ST_IDLE : rgsc_pkg::ST_CLEAR;
         end
         default: state_in = rgsc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.reason = reason_ff;
      unique case (state_ff)
         rgsc_pkg::ST_CLEAR:     cmd.clear     = 1'b1;
         rgsc_pkg::ST_IDLE:      cmd.take      = 1'b1;
         rgsc_pkg::ST_ROOT_RD:   cmd.root_rd   = 1'b1;
         rgsc_pkg::ST_NB_INIT:   cmd.nb_init   = 1'b1;
         rgsc_pkg::ST_NB_PICK:   cmd.nb_pick   = !sts.nb_empty;
         rgsc_pkg::ST_UPD_RD_A:  cmd.upd_rd_a  = 1'b1;
         rgsc_pkg::ST_UPD_WR_A:  cmd.upd_wr_a  = 1'b1;
         rgsc_pkg::ST_UPD_RD_B:  cmd.upd_rd_b  = 1'b1;
         rgsc_pkg::ST_UPD_WR_B:  cmd.upd_wr_b  = 1'b1;
         rgsc_pkg::ST_NB_DONE:   cmd.reason    = reason_ff;
         rgsc_pkg::ST_WALK_INIT: cmd.walk_init = 1'b1;
         rgsc_pkg::ST_DEQ:       cmd.deq       = !sts.q_a_empty && !sts.q_b_empty;
         rgsc_pkg::ST_NODE_RD:   cmd.node_rd   = 1'b1;
         rgsc_pkg::ST_NODE_LOAD: cmd.node_load = 1'b1;
         rgsc_pkg::ST_ENQ:       cmd.enq       = 1'b1;
         rgsc_pkg::ST_WALK_END:  cmd.reason    = reason_ff;
         rgsc_pkg::ST_EMIT:      cmd.emit      = sts.rsp_free;
         default:                cmd           = '0;
      endcase
   end

endmodule

// File: hw/rtl/rgsc_dp.sv
// datapath: atom stores, walk queues, element difference counters and result register
module rgsc_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rgsc_pkg::cmd_type                     cmd,
   output rgsc_pkg::sts_type                     sts,
   input  logic                                  req_valid,
   input  logic [1:0]                            req_action,
   input  logic [rgsc_pkg::IDX_BITS-1:0]         req_atom_index,
   input  logic [rgsc_pkg::ELEMENT_BITS-1:0]     req_atomic_number,
   input  logic [rgsc_pkg::MAX_ATOMS-1:0]        req_neighbor_row,
   input  logic [rgsc_pkg::IDX_BITS-1:0]         req_first_atom,
   input  logic [rgsc_pkg::IDX_BITS-1:0]         req_second_atom,
   input  logic                                  req_across_molecules,
   input  logic                                  csr_wr_en,
   input  logic [rgsc_pkg::CNT_BITS-1:0]         csr_wr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_equivalent,
   output logic [2:0]                            rsp_fail_reason
);

   localparam int N  = rgsc_pkg::MAX_ATOMS;
   localparam int IB = rgsc_pkg::IDX_BITS;
   localparam int CB = rgsc_pkg::CNT_BITS;
   localparam int EB = rgsc_pkg::ELEMENT_BITS;
   localparam int LB = rgsc_pkg::LEVEL_BITS;
   localparam int QB = rgsc_pkg::QE_BITS;
   localparam int DB = rgsc_pkg::DIFF_BITS;
   localparam int ZB = rgsc_pkg::NZ_BITS;

   // atom count register and in-use mask
   logic [CB-1:0] atom_count_ff;
   logic [CB-1:0] eff_count;
   logic [N-1:0]  mask;

   always_ff @(posedge clock) begin
      if (reset) atom_count_ff <= CB'(N);
      else if (csr_wr_en) atom_count_ff <= csr_wr_data;
   end

   always_comb begin
      if (atom_count_ff == '0) eff_count = CB'(1);
      else if (atom_count_ff > CB'(N)) eff_count = CB'(N);
      else eff_count = atom_count_ff;
      for (int k = 0; k < N; k++) mask[k] = CB'(k) < eff_count;
   end

   // atom stores
   logic [N-1:0]  adj_first_mem  [N];
   logic [N-1:0]  adj_second_mem [N];
   logic [EB-1:0] el_first_mem   [N];
   logic [EB-1:0] el_second_mem  [N];

   logic accepted;
   assign accepted = req_valid && cmd.take;

   always_ff @(posedge clock) begin
      if (accepted && req_action == rgsc_pkg::ACT_LOAD_FIRST) begin
         adj_first_mem[req_atom_index] <= req_neighbor_row;
         el_first_mem[req_atom_index]  <= req_atomic_number;
      end
      if (accepted && req_action == rgsc_pkg::ACT_LOAD_SECOND) begin
         adj_second_mem[req_atom_index] <= req_neighbor_row;
         el_second_mem[req_atom_index]  <= req_atomic_number;
      end
   end

   // compare operands
   logic [IB-1:0] p_ff, q_ff;
   logic          across_ff;

   always_ff @(posedge clock) begin
      if (accepted && req_action == rgsc_pkg::ACT_COMPARE) begin
         p_ff      <= req_first_atom;
         q_ff      <= req_second_atom;
         across_ff <= req_across_molecules;
      end
   end

   // queue words and store reads
   logic [QB-1:0] q_a_rd_ff, q_b_rd_ff;
   logic [IB-1:0] u_a, u_b;
   logic [LB-1:0] lv_a, lv_b;
   assign u_a  = q_a_rd_ff[QB-1:LB];
   assign lv_a = q_a_rd_ff[LB-1:0];
   assign u_b  = q_b_rd_ff[QB-1:LB];
   assign lv_b = q_b_rd_ff[LB-1:0];

   logic [N-1:0]  nbp_ff;
   logic [IB-1:0] pick_idx;
   assign pick_idx = rgsc_pkg::lowest_bit(nbp_ff);

   logic [IB-1:0] rd_addr_a, rd_addr_b;
   logic          rd_en;
   logic [N-1:0]  adj_a_ff, adj_fb_ff, adj_sb_ff, adj_b;
   logic [EB-1:0] el_a_ff, el_fb_ff, el_sb_ff, el_b;

   always_comb begin
      if (cmd.root_rd) begin
         rd_addr_a = p_ff;
         rd_addr_b = q_ff;
      end else if (cmd.nb_pick) begin
         rd_addr_a = pick_idx;
         rd_addr_b = pick_idx;
      end else begin
         rd_addr_a = u_a;
         rd_addr_b = u_b;
      end
   end
   assign rd_en = cmd.root_rd || cmd.nb_pick || cmd.node_rd;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         adj_a_ff  <= adj_first_mem[rd_addr_a];
         adj_fb_ff <= adj_first_mem[rd_addr_b];
         adj_sb_ff <= adj_second_mem[rd_addr_b];
         el_a_ff   <= el_first_mem[rd_addr_a];
         el_fb_ff  <= el_first_mem[rd_addr_b];
         el_sb_ff  <= el_second_mem[rd_addr_b];
      end
   end

   assign adj_b = across_ff ? adj_sb_ff : adj_fb_ff;
   assign el_b  = across_ff ? el_sb_ff : el_fb_ff;

   // neighbor rows, visited sets, degree counts
   logic [N-1:0]  row_a_ff, row_b_ff, vis_a_ff, vis_b_ff;
   logic          ra_bit_ff, rb_bit_ff;
   logic [CB-1:0] cnt_a_ff, cnt_b_ff;
   logic [IB-1:0] enq_a, enq_b;
   logic [LB-1:0] prev_ff;

   assign enq_a = rgsc_pkg::lowest_bit(row_a_ff);
   assign enq_b = rgsc_pkg::lowest_bit(row_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.nb_init) begin
         row_a_ff <= adj_a_ff & mask;
         row_b_ff <= adj_b & mask;
         nbp_ff   <= (adj_a_ff | adj_b) & mask;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end
      if (cmd.nb_pick) begin
         nbp_ff[pick_idx] <= 1'b0;
         ra_bit_ff        <= row_a_ff[pick_idx];
         rb_bit_ff        <= row_b_ff[pick_idx];
         cnt_a_ff         <= cnt_a_ff + CB'(row_a_ff[pick_idx]);
         cnt_b_ff         <= cnt_b_ff + CB'(row_b_ff[pick_idx]);
      end
      if (cmd.walk_init) begin
         vis_a_ff <= N'(1) << p_ff;
         vis_b_ff <= N'(1) << q_ff;
         prev_ff  <= '0;
      end
      if (cmd.node_rd) prev_ff <= lv_a;
      if (cmd.node_load) begin
         row_a_ff  <= adj_a_ff & mask & ~vis_a_ff;
         row_b_ff  <= adj_b & mask & ~vis_b_ff;
         ra_bit_ff <= 1'b1;
         rb_bit_ff <= 1'b1;
      end
      if (cmd.enq) begin
         if (row_a_ff != '0) begin
            row_a_ff[enq_a] <= 1'b0;
            vis_a_ff[enq_a] <= 1'b1;
         end
         if (row_b_ff != '0) begin
            row_b_ff[enq_b] <= 1'b0;
            vis_b_ff[enq_b] <= 1'b1;
         end
      end
   end

   // walk queues
   logic [QB-1:0] q_a_mem [N];
   logic [QB-1:0] q_b_mem [N];
   logic [CB-1:0] f_a_ff, r_a_ff, f_b_ff, r_b_ff;
   logic          qw_a, qw_b;
   logic [IB-1:0] qw_addr_a, qw_addr_b;
   logic [QB-1:0] qw_data_a, qw_data_b;

   assign qw_a      = cmd.walk_init || (cmd.enq && row_a_ff != '0);
   assign qw_b      = cmd.walk_init || (cmd.enq && row_b_ff != '0);
   assign qw_addr_a = cmd.walk_init ? '0 : r_a_ff[IB-1:0];
   assign qw_addr_b = cmd.walk_init ? '0 : r_b_ff[IB-1:0];
   assign qw_data_a = cmd.walk_init ? {p_ff, LB'(0)} : {enq_a, lv_a + LB'(1)};
   assign qw_data_b = cmd.walk_init ? {q_ff, LB'(0)} : {enq_b, lv_b + LB'(1)};

   always_ff @(posedge clock) begin
      if (qw_a) q_a_mem[qw_addr_a] <= qw_data_a;
      if (qw_b) q_b_mem[qw_addr_b] <= qw_data_b;
      if (cmd.deq) begin
         q_a_rd_ff <= q_a_mem[f_a_ff[IB-1:0]];
         q_b_rd_ff <= q_b_mem[f_b_ff[IB-1:0]];
      end
   end

   // element difference counters
   logic [DB-1:0] diff_mem [rgsc_pkg::ELEM_VALUES];
   logic [DB-1:0] diff_rd_ff, diff_wdata;
   logic [EB-1:0] diff_addr, diff_waddr, clr_idx_ff;
   logic          diff_we, same_el;
   logic [ZB-1:0] nz_ff;

   assign same_el    = el_a_ff == el_b;
   assign diff_addr  = (cmd.upd_rd_b || cmd.upd_wr_b) ? el_b : el_a_ff;
   assign diff_we    = cmd.upd_wr_a || cmd.upd_wr_b || cmd.clear;
   assign diff_waddr = cmd.clear ? clr_idx_ff : diff_addr;
   assign diff_wdata = cmd.clear ? '0 :
                       (cmd.upd_wr_a ? diff_rd_ff + DB'(1) : diff_rd_ff - DB'(1));

   always_ff @(posedge clock) begin
      if (diff_we) diff_mem[diff_waddr] <= diff_wdata;
      if (cmd.upd_rd_a || cmd.upd_rd_b) diff_rd_ff <= diff_mem[diff_addr];
   end

   // control registers and result word
   logic       rsp_valid_ff, rsp_equivalent_ff;
   logic [2:0] rsp_fail_reason_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_a_ff       <= '0;
         r_a_ff       <= '0;
         f_b_ff       <= '0;
         r_b_ff       <= '0;
         nz_ff        <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.walk_init) begin
            f_a_ff <= '0;
            f_b_ff <= '0;
            r_a_ff <= CB'(1);
            r_b_ff <= CB'(1);
         end
         if (cmd.deq) begin
            f_a_ff <= f_a_ff + CB'(1);
            f_b_ff <= f_b_ff + CB'(1);
         end
         if (cmd.enq && row_a_ff != '0) r_a_ff <= r_a_ff + CB'(1);
         if (cmd.enq && row_b_ff != '0) r_b_ff <= r_b_ff + CB'(1);
         if (cmd.clear) begin
            nz_ff      <= '0;
            clr_idx_ff <= clr_idx_ff + EB'(1);
         end else if (cmd.upd_wr_a || cmd.upd_wr_b) begin
            if (diff_rd_ff == '0 && diff_wdata != '0) nz_ff <= nz_ff + ZB'(1);
            else if (diff_rd_ff != '0 && diff_wdata == '0) nz_ff <= nz_ff - ZB'(1);
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_equivalent_ff  <= cmd.reason == rgsc_pkg::FAIL_NONE;
         rsp_fail_reason_ff <= cmd.reason;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_equivalent  = rsp_equivalent_ff;
   assign rsp_fail_reason = rsp_fail_reason_ff;

   always_comb begin
      sts.req_is_cmp = req_action == rgsc_pkg::ACT_COMPARE;
      sts.root_bad   = !mask[req_first_atom] || !mask[req_second_atom];
      sts.nb_empty   = nbp_ff == '0;
      sts.cnt_eq     = cnt_a_ff == cnt_b_ff;
      sts.nz_zero    = nz_ff == '0;
      sts.q_a_empty  = f_a_ff == r_a_ff;
      sts.q_b_empty  = f_b_ff == r_b_ff;
      sts.lv_eq      = lv_a == lv_b;
      sts.lv_changed = lv_a != prev_ff;
      sts.inc_en     = ra_bit_ff && !(rb_bit_ff && same_el);
      sts.dec_en     = rb_bit_ff && !(ra_bit_ff && same_el);
      sts.enq_empty  = row_a_ff == '0 && row_b_ff == '0;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
      sts.clear_done = clr_idx_ff == EB'(rgsc_pkg::ELEM_VALUES - 1);
   end

endmodule
